/* hdl/lpht_pkg.sv */
// Package for the linear-probe hash table: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package lpht_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam bit IS_POW2     = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;
  localparam int MARK_W = 2;
  localparam int DATA_W = KEY_W + VAL_W;
  localparam int IN_TDATA_W = ((DATA_W + 7) / 8) * 8;

  // Home-slot remainder unit: MOD_BITS key bits per cycle
  localparam int MOD_BITS = 4;
  localparam int KEY_PAD  = ((KEY_W + MOD_BITS - 1) / MOD_BITS) * MOD_BITS;
  localparam int MOD_CYC  = KEY_PAD / MOD_BITS;
  localparam int MODC_W   = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Slot marks
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_BUSY    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;     // sweep one slot of the mark store to empty
    logic load;      // capture the incoming transaction
    logic mod_step;  // one step of the home-slot remainder
    logic probe;     // issue/check one probe slot
    logic commit;    // update the store and load the result register
  } lpht_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic mod_last;
    logic probe_done;
  } lpht_stat_t;

endpackage

/* hdl/lpht_ram.sv */
// Generic single-port RAM with registered read data.
// Used for the slot mark store and the slot key/value store. No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read registered at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lpht_datapath.sv */
// Datapath of the hash table: request registers, home-slot remainder,
// pipelined probe over the slot stores, commit logic and result register.
// Depends on lpht_pkg and lpht_ram.
module lpht_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpht_pkg::lpht_cmd_t        cmd_i,
  output lpht_pkg::lpht_stat_t       stat_o,
  input  logic [lpht_pkg::REQ_W-1:0] req_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  input  logic [lpht_pkg::VAL_W-1:0] val_i,
  output logic [lpht_pkg::STAT_W-1:0] res_stat_o,
  output logic [lpht_pkg::VAL_W-1:0]  res_val_o
);
  import lpht_pkg::*;

  localparam logic [SLOT_W:0] SLOT_NUM  = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam slot_t           SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  // Request registers
  logic [REQ_W-1:0]   req_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [KEY_PAD-1:0] keysh_q;
  logic [MODC_W-1:0]  modc_q;
  slot_t              rem_q, rem_d;

  // Probe state
  slot_t              iss_pos_q, chk_pos_q, clr_q;
  logic [CNT_W-1:0]   iss_cnt_q, chk_cnt_q;
  logic               chk_valid_q;
  logic               hit_q, free_q;
  slot_t              hit_pos_q, free_pos_q;
  logic [VAL_W-1:0]   hit_val_q;

  // Result register
  logic [STAT_W-1:0]  res_stat_q;
  logic [VAL_W-1:0]   res_val_q;

  // Store ports
  slot_t              ram_addr;
  logic               mark_we, data_we;
  logic [MARK_W-1:0]  mark_wdata, mark_rd;
  logic [DATA_W-1:0]  data_rd;

  // Check and commit signals
  logic               is_empty, is_hit, is_tomb, lap_end, iss_more;
  logic               c_mark_we, c_data_we;
  logic [MARK_W-1:0]  c_mark;
  slot_t              c_pos;
  logic [STAT_W-1:0]  c_stat;
  logic [VAL_W-1:0]   c_val;

  // Remainder of the key by the slot count, MOD_BITS bits per step
  always_comb begin
    logic [SLOT_W:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[SLOT_W-1:0], keysh_q[KEY_PAD-1-i]};
      if (r >= SLOT_NUM) begin
        r = r - SLOT_NUM;
      end
    end
    rem_d = r[SLOT_W-1:0];
  end

  // Evaluate the slot read in the previous cycle
  assign is_empty = chk_valid_q && (mark_rd == MARK_EMPTY);
  assign is_hit   = chk_valid_q && (mark_rd == MARK_BUSY) && (data_rd[KEY_W-1:0] == key_q);
  assign is_tomb  = chk_valid_q && (mark_rd != MARK_EMPTY) && (mark_rd != MARK_BUSY);
  assign lap_end  = chk_valid_q && (chk_cnt_q == CNT_W'(TABLE_SLOTS - 1));
  assign iss_more = (iss_cnt_q != CNT_W'(TABLE_SLOTS));

  assign stat_o.probe_done = is_empty || is_hit || lap_end;
  assign stat_o.mod_last   = (modc_q == MODC_W'(MOD_CYC - 1));
  assign stat_o.clear_done = (clr_q == SLOT_LAST);

  // Commit decision
  always_comb begin
    c_mark_we = 1'b0;
    c_data_we = 1'b0;
    c_mark    = MARK_BUSY;
    c_pos     = hit_pos_q;
    c_stat    = ST_MISS;
    c_val     = '0;
    unique case (req_q)
      REQ_INSERT: begin
        if (hit_q) begin
          c_data_we = 1'b1;
          c_stat    = ST_OK;
        end else if (free_q) begin
          c_mark_we = 1'b1;
          c_data_we = 1'b1;
          c_pos     = free_pos_q;
          c_stat    = ST_OK;
        end else begin
          c_stat = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (hit_q) begin
          c_stat = ST_OK;
          c_val  = hit_val_q;
        end
      end
      REQ_DELETE: begin
        if (hit_q) begin
          c_mark_we = 1'b1;
          c_mark    = MARK_DELETED;
          c_stat    = ST_OK;
        end
      end
      default: c_stat = ST_MISS;
    endcase
  end

  // Store address and write controls
  always_comb begin
    if (cmd_i.clear) begin
      ram_addr = clr_q;
    end else if (cmd_i.commit) begin
      ram_addr = c_pos;
    end else begin
      ram_addr = iss_pos_q;
    end
  end
  assign mark_we    = cmd_i.clear || (cmd_i.commit && c_mark_we);
  assign mark_wdata = cmd_i.clear ? MARK_EMPTY : c_mark;
  assign data_we    = cmd_i.commit && c_data_we;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      modc_q      <= '0;
      iss_cnt_q   <= '0;
      chk_cnt_q   <= '0;
      chk_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= stat_o.clear_done ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        modc_q      <= '0;
        iss_cnt_q   <= '0;
        chk_cnt_q   <= '0;
        chk_valid_q <= 1'b0;
        hit_q       <= 1'b0;
        free_q      <= 1'b0;
      end else if (cmd_i.mod_step) begin
        modc_q <= modc_q + 1'b1;
      end else if (cmd_i.probe) begin
        chk_valid_q <= iss_more;
        if (iss_more) begin
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
        if (chk_valid_q) begin
          chk_cnt_q <= chk_cnt_q + 1'b1;
        end
        if (is_hit) begin
          hit_q <= 1'b1;
        end
        if ((is_empty || is_tomb) && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_i;
      key_q     <= key_i;
      val_q     <= val_i;
      keysh_q   <= KEY_PAD'(key_i);
      rem_q     <= '0;
      iss_pos_q <= IS_POW2 ? key_i[SLOT_W-1:0] : '0;
    end else if (cmd_i.mod_step) begin
      keysh_q <= {keysh_q[KEY_PAD-MOD_BITS-1:0], MOD_BITS'(0)};
      rem_q   <= rem_d;
      if (stat_o.mod_last) begin
        iss_pos_q <= rem_d;
      end
    end else if (cmd_i.probe) begin
      if (iss_more) begin
        iss_pos_q <= (iss_pos_q == SLOT_LAST) ? '0 : iss_pos_q + 1'b1;
        chk_pos_q <= iss_pos_q;
      end
      if (is_hit) begin
        hit_pos_q <= chk_pos_q;
        hit_val_q <= data_rd[DATA_W-1:KEY_W];
      end
      if ((is_empty || is_tomb) && !free_q) begin
        free_pos_q <= chk_pos_q;
      end
    end
    if (cmd_i.commit) begin
      res_stat_q <= c_stat;
      res_val_q  <= c_val;
    end
  end

  // Slot stores
  lpht_ram #(.WIDTH(MARK_W), .DEPTH(TABLE_SLOTS)) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .addr_i (ram_addr),
    .wdata_i(mark_wdata),
    .rdata_o(mark_rd)
  );

  lpht_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SLOTS)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .addr_i (ram_addr),
    .wdata_i({val_q, key_q}),
    .rdata_o(data_rd)
  );

  assign res_stat_o = res_stat_q;
  assign res_val_o  = res_val_q;

endmodule

/* hdl/lpht_ctrl.sv */
// Controller of the hash table: clear sweep, request sequencing and the
// output valid flag. Depends on lpht_pkg.
module lpht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpht_pkg::lpht_cmd_t  cmd_o,
  input  lpht_pkg::lpht_stat_t stat_i
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = IS_POW2 ? S_PROBE : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (stat_i.probe_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/linear_probe_hash_table.sv */
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, lpht_ctrl, lpht_datapath (and lpht_ram below it).
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind
//   (insert/update, lookup, delete), tdata the key and the value.
//   Each request yields exactly one response on m_axis: tuser carries the
//   status (done/found, not found, table full), tdata the value read on a
//   lookup hit, zero otherwise.
//   Sequence: the request is accepted, then the home-slot remainder is
//   formed when the slot count is not a power of two, then the slot
//   stores are probed (one slot read per cycle, ending at an empty slot,
//   a hit or a full lap), then the store and the result register are
//   committed. One request is in work at a time. After reset the mark
//   store is swept to empty, one slot per cycle; s_axis_tready stays low
//   during the sweep.
//   The response sits in an output register: a new request is accepted
//   while it waits, but the next response is held back until the receiver
//   takes the pending one.
module linear_probe_hash_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [30:0] key, [94:31] value, [95] zero
  input  logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [lpht_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] read_value
  output logic [lpht_pkg::VAL_W-1:0]          m_axis_tdata,
  // [1:0] status
  output logic [lpht_pkg::STAT_W-1:0]         m_axis_tuser
);
  import lpht_pkg::*;

  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  lpht_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .req_i     (s_axis_tuser),
    .key_i     (s_axis_tdata[KEY_W-1:0]),
    .val_i     (s_axis_tdata[DATA_W-1:KEY_W]),
    .res_stat_o(m_axis_tuser),
    .res_val_o (m_axis_tdata)
  );

endmodule

/* hdl/lpht_checker.sv */
// Port-level assertions for the hash table top level, with the bind that
// attaches them. Depends on lpht_pkg and linear_probe_hash_table.
module lpht_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [lpht_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input logic [lpht_pkg::REQ_W-1:0]      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lpht_pkg::VAL_W-1:0]      m_axis_tdata,
  input logic [lpht_pkg::STAT_W-1:0]     m_axis_tuser
);
  import lpht_pkg::*;

  // A waiting request holds its contents
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("request changed while waiting");

  // A stalled response holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("response changed while stalled");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_MISS) ||
                      (m_axis_tuser == ST_FULL))
    else $error("undefined status code");

  // Read value is zero unless the request succeeded
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero read value on a failed request");

  // One request in work at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in work");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

/* verif/tb_linear_probe_hash_table.sv */
// Self-checking testbench for linear_probe_hash_table: directed and random
// insert/lookup/delete requests checked against a slot-level table model.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  // Request code the block leaves unused; it must answer "not found"
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  localparam int NUM_PHASES     = 4;
  localparam int RAND_PER_PHASE = 420;
  localparam int POOL_SIZE      = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } hash_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } hash_resp_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [VAL_W-1:0]      m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  // Local copy of the slot stores
  logic [MARK_W-1:0] slot_mark  [TABLE_SLOTS];
  logic [KEY_W-1:0]  slot_key   [TABLE_SLOTS];
  logic [VAL_W-1:0]  slot_value [TABLE_SLOTS];

  hash_req_t  req_q[$];          // requests waiting to be sent
  hash_resp_t pending_resp_q[$]; // responses owed by the block
  bit         req_taken = 1'b0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         mismatch_cnt   = 0;
  int         cycle_cnt      = 0;

  linear_probe_hash_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the table copy and return the response it owes
  function automatic hash_resp_t hash_apply(hash_req_t r);
    hash_resp_t res;
    int         pos;
    int         free_at;
    int         hit;
    bit         stop;
    res.status     = ST_MISS;
    res.read_value = '0;
    free_at        = -1;
    hit            = -1;
    stop           = 1'b0;
    pos            = int'(r.key % TABLE_SLOTS);
    // Probe from the home slot: stop at an empty slot, a busy hit or a full lap
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!stop) begin
        if (slot_mark[pos] == MARK_EMPTY) begin
          if (free_at < 0) free_at = pos;
          stop = 1'b1;
        end else if (slot_mark[pos] == MARK_BUSY) begin
          if (slot_key[pos] == r.key) begin
            hit  = pos;
            stop = 1'b1;
          end
        end else if (free_at < 0) begin
          free_at = pos;
        end
        if (!stop) pos = (pos + 1) % TABLE_SLOTS;
      end
    end
    case (r.kind)
      REQ_INSERT: begin
        if (hit >= 0) begin
          slot_value[hit] = r.value;
          res.status      = ST_OK;
        end else if (free_at >= 0) begin
          slot_mark[free_at]  = MARK_BUSY;
          slot_key[free_at]   = r.key;
          slot_value[free_at] = r.value;
          res.status          = ST_OK;
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          res.read_value = slot_value[hit];
          res.status     = ST_OK;
        end
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          slot_mark[hit] = MARK_DELETED;
          res.status     = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] exp_v,
                                 logic [VAL_W-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // Request driver: presents queued requests and the random receiver ready at the falling edge
  always @(negedge clk_i) begin : req_driver
    hash_req_t nxt;
    bit        go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!s_axis_tvalid || req_taken) begin
        go = (req_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (go) begin
          nxt = req_q.pop_front();
          s_axis_tuser <= nxt.kind;
          s_axis_tdata <= IN_TDATA_W'({nxt.value, nxt.key});
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each response
  always @(posedge clk_i) begin : resp_monitor
    hash_req_t  acc;
    hash_resp_t exp_r;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.kind  = s_axis_tuser;
        acc.key   = s_axis_tdata[KEY_W-1:0];
        acc.value = s_axis_tdata[KEY_W +: VAL_W];
        pending_resp_q.push_back(hash_apply(acc));
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_resp_q.size() == 0) begin
          report_mismatch("unexpected response, status/value", VAL_W'(m_axis_tuser),
                          m_axis_tdata);
        end else begin
          exp_r = pending_resp_q.pop_front();
          if (m_axis_tuser !== exp_r.status)
            report_mismatch("status", VAL_W'(exp_r.status), VAL_W'(m_axis_tuser));
          if (m_axis_tdata !== exp_r.read_value)
            report_mismatch("read_value", exp_r.read_value, m_axis_tdata);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: reset, directed table walk, then random phases
  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    hash_req_t        r;
    int               pick;
    int               send_pct [NUM_PHASES];
    int               recv_pct [NUM_PHASES];
    send_pct = '{0, 64, 0, 18};
    recv_pct = '{0, 0, 64, 18};
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_mark[i]  = MARK_EMPTY;
      slot_key[i]   = '0;
      slot_value[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      // Key pool: half the keys crowd into the first few home slots
      for (int i = 0; i < POOL_SIZE; i++) begin
        key_pool[i] = KEY_W'($urandom);
        if (i % 2 == 0) key_pool[i] = KEY_W'(key_pool[i] - (key_pool[i] % TABLE_SLOTS)
                                      + $urandom_range(3));
      end
      if (ph == 0) begin
        req_q.push_back('{REQ_INSERT, '0, '0});
        req_q.push_back('{REQ_INSERT, KEY_MAX, '1});
        req_q.push_back('{REQ_INSERT, 31'd16, 64'h0123_4567_89ab_cdef});
        req_q.push_back('{REQ_LOOKUP, 31'd16, '1});
        req_q.push_back('{REQ_LOOKUP, KEY_MAX, '0});
        req_q.push_back('{REQ_LOOKUP, 31'd32, '0});
        // update in place, then delete and look past the tombstone
        req_q.push_back('{REQ_INSERT, '0, 64'hfeed_face_dead_beef});
        req_q.push_back('{REQ_LOOKUP, '0, '0});
        req_q.push_back('{REQ_DELETE, '0, '0});
        req_q.push_back('{REQ_LOOKUP, '0, '0});
        req_q.push_back('{REQ_DELETE, '0, '0});
        req_q.push_back('{REQ_LOOKUP, 31'd16, '0});
        req_q.push_back('{REQ_INSERT, 31'd16, 64'h5555_aaaa_5555_aaaa});
        req_q.push_back('{REQ_INSERT, 31'd48, 64'haaaa_5555_aaaa_5555});
        req_q.push_back('{REQ_LOOKUP, 31'd48, '0});
        // wrap-around from the last slot
        req_q.push_back('{REQ_INSERT, 31'd15, 64'h8000_0000_0000_0001});
        req_q.push_back('{REQ_LOOKUP, 31'd15, '0});
        req_q.push_back('{REQ_UNUSED, 31'd16, '1});
        req_q.push_back('{REQ_DELETE, KEY_MAX, '0});
        req_q.push_back('{REQ_LOOKUP, 31'd15, '0});
        req_q.push_back('{REQ_LOOKUP, KEY_MAX, '0});
        req_q.push_back('{REQ_DELETE, 31'd99, '0});
      end
      repeat (RAND_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 40)      r.kind = REQ_INSERT;
        else if (pick < 70) r.kind = REQ_LOOKUP;
        else if (pick < 95) r.kind = REQ_DELETE;
        else                r.kind = REQ_UNUSED;
        if ($urandom_range(4) == 0) r.key = KEY_W'($urandom);
        else                        r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        pick = $urandom_range(15);
        if (pick == 0)      r.value = '0;
        else if (pick == 1) r.value = '1;
        else                r.value = {$urandom, $urandom};
        req_q.push_back(r);
      end
      // Hold off the next phase until the block has answered everything
      do @(posedge clk_i);
      while (req_q.size() != 0 || s_axis_tvalid || pending_resp_q.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatch_cnt += pending_resp_q.size();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
